@@ hdl/rcw_pkg.sv @@
// Shared types and constants for the Reno congestion window block.
package rcw_pkg;

  localparam int unsigned WINDOW_BITS_DEF   = 16;
  localparam int unsigned MAX_ACKS_DEF      = 255;
  localparam int unsigned FIELD_BITS        = 16;
  localparam int unsigned ACK_BITS          = 8;
  localparam int unsigned MODE_BITS         = 2;
  localparam int unsigned ADDR_BITS         = 4;
  localparam int unsigned DATA_BITS         = 32;

  localparam logic [FIELD_BITS-1:0] LIMIT_RESET     = 16'd1024;
  localparam logic [FIELD_BITS-1:0] WIN_INIT_RESET  = 16'd10;
  localparam logic [FIELD_BITS-1:0] THRESH_RESET    = 16'd64;
  localparam int unsigned           MIN_THRESHOLD   = 2;
  localparam int unsigned           TIMEOUT_WINDOW  = 1;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_NONE    = 2'd0,
    MODE_FAST    = 2'd1,
    MODE_TIMEOUT = 2'd2,
    MODE_SPARE   = 2'd3
  } loss_mode_t;

  typedef enum logic [1:0] {
    REG_WINDOW_LIMIT      = 2'd0,
    REG_WINDOW_INITIAL    = 2'd1,
    REG_THRESHOLD_INITIAL = 2'd2,
    REG_NONE              = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_LOSS,
    ST_DONE
  } state_t;

endpackage

@@ hdl/reno_congestion_window_top.sv @@
// Packet-counting Reno congestion window: sequencer, ack/loss unit and APB registers.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one ack event: acked_count
//   newly acknowledged packets and a loss mode (none, fast retransmit,
//   timeout; the spare code means no loss).
//   Output channel (out_valid / out_stall) returns the window and the
//   slow-start threshold after that event, one result per event.
//   Sequence: the transfer, then the acks applied one by one (capped at
//   MAX_ACKS_PER_EVENT), a check that finds the count spent, the loss step and
//   the output load; the next event is taken only after the result is loaded.
//   The single ack update unit does one ack per cycle, which sets the rate;
//   in_stall is high from the transfer until the result is loaded, and in reset.
//   If the output register still holds an untaken result, the finished
//   event waits in the done state until out_stall drops.
//   Reset (rst, synchronous) loads limit 1024, initial window 10, initial
//   threshold 64, window 10, threshold 64, accumulator 0, no result pending.
//   APB writes (idle only): window_initial also reloads the window and
//   clears the accumulator; threshold_initial also reloads the threshold.
module reno_congestion_window_top #(
  parameter int unsigned WINDOW_BITS        = rcw_pkg::WINDOW_BITS_DEF,
  parameter int unsigned MAX_ACKS_PER_EVENT = rcw_pkg::MAX_ACKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // event input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rcw_pkg::ACK_BITS-1:0]     acked_count,
  input  logic [rcw_pkg::MODE_BITS-1:0]    mode,
  // result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rcw_pkg::FIELD_BITS-1:0]   window,
  output logic [rcw_pkg::FIELD_BITS-1:0]   threshold,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rcw_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [rcw_pkg::DATA_BITS-1:0]    pwdata,
  output logic [rcw_pkg::DATA_BITS-1:0]    prdata,
  output logic                             pready
);

  localparam int unsigned WB = WINDOW_BITS;
  localparam logic [32:0] WIN_MAX = (33'd1 << WB) - 33'd1;
  localparam int unsigned ACK_MAX_ALL = (1 << rcw_pkg::ACK_BITS) - 1;
  localparam logic [rcw_pkg::ACK_BITS-1:0] ACK_CAP =
    (MAX_ACKS_PER_EVENT > ACK_MAX_ALL) ? rcw_pkg::ACK_BITS'(ACK_MAX_ALL)
                                       : rcw_pkg::ACK_BITS'(MAX_ACKS_PER_EVENT);
  localparam logic [rcw_pkg::ACK_BITS-1:0] ACK_ONE = rcw_pkg::ACK_BITS'(1);
  localparam logic [WB-1:0] ONE_W     = WB'(1);
  localparam logic [WB-1:0] MIN_THR_W = WB'(rcw_pkg::MIN_THRESHOLD);
  localparam logic [WB-1:0] TO_WIN_W  = WB'(rcw_pkg::TIMEOUT_WINDOW);
  localparam logic [31:0]   WIN_INIT_X = {16'd0, rcw_pkg::WIN_INIT_RESET};
  localparam logic [31:0]   THRESH_X   = {16'd0, rcw_pkg::THRESH_RESET};

  // configuration registers
  logic [rcw_pkg::FIELD_BITS-1:0] window_limit;
  logic [rcw_pkg::FIELD_BITS-1:0] window_initial;
  logic [rcw_pkg::FIELD_BITS-1:0] threshold_initial;

  // congestion state
  logic [WB-1:0] cwnd, cwnd_next;
  logic [WB-1:0] ssthresh, ssthresh_next;
  logic [WB-1:0] acc, acc_next;

  // event held during processing
  logic [rcw_pkg::ACK_BITS-1:0] ack_left;
  rcw_pkg::loss_mode_t          loss_mode;

  rcw_pkg::state_t state, state_next;

  // control
  logic take_event, do_ack, do_loss, load_out;

  // APB decode
  rcw_pkg::reg_index_t reg_idx;
  logic                cfg_write;
  logic [31:0]         wdata_x;

  assign pready    = 1'b1;
  assign reg_idx   = rcw_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_write = psel & penable & pwrite & pready;
  assign wdata_x   = {16'd0, pwdata[15:0]};

  always_comb begin
    case (reg_idx)
      rcw_pkg::REG_WINDOW_LIMIT:      prdata = {16'd0, window_limit};
      rcw_pkg::REG_WINDOW_INITIAL:    prdata = {16'd0, window_initial};
      rcw_pkg::REG_THRESHOLD_INITIAL: prdata = {16'd0, threshold_initial};
      default:                        prdata = '0;
    endcase
  end

  // effective limit: register value clamped to the largest value of the window width
  logic [31:0]   lim_x;
  logic [WB-1:0] eff_lim;
  assign lim_x   = {16'd0, window_limit};
  assign eff_lim = (lim_x <= WIN_MAX[31:0]) ? lim_x[WB-1:0] : '1;

  // shared update unit: one ack or one loss step per cycle
  logic [WB-1:0] ack_cwnd, acc_inc, half, loss_cwnd;
  always_comb begin
    ack_cwnd = cwnd;
    acc_next = acc;
    acc_inc  = acc + ONE_W;
    if (cwnd < ssthresh) begin
      ack_cwnd = cwnd + ONE_W;
    end else begin
      acc_next = acc_inc;
      if (acc_inc >= cwnd) begin
        acc_next = '0;
        if (cwnd < eff_lim) ack_cwnd = cwnd + ONE_W;
      end
    end
    if (ack_cwnd > eff_lim) ack_cwnd = eff_lim;

    half = cwnd >> 1;
    if (half < MIN_THR_W) half = MIN_THR_W;
    loss_cwnd = (loss_mode == rcw_pkg::MODE_FAST) ? half : TO_WIN_W;
    if (loss_cwnd > eff_lim) loss_cwnd = eff_lim;

    cwnd_next     = cwnd;
    ssthresh_next = ssthresh;
    if (do_ack) begin
      cwnd_next = ack_cwnd;
    end else if (do_loss) begin
      if (loss_mode == rcw_pkg::MODE_FAST || loss_mode == rcw_pkg::MODE_TIMEOUT) begin
        cwnd_next     = loss_cwnd;
        ssthresh_next = half;
        acc_next      = '0;
      end else begin
        acc_next = acc;
      end
    end else begin
      acc_next = acc;
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      rcw_pkg::ST_IDLE: if (in_valid) state_next = rcw_pkg::ST_ACK;
      rcw_pkg::ST_ACK:  if (ack_left == '0) state_next = rcw_pkg::ST_LOSS;
      rcw_pkg::ST_LOSS: state_next = rcw_pkg::ST_DONE;
      rcw_pkg::ST_DONE: if (!out_valid || !out_stall) state_next = rcw_pkg::ST_IDLE;
      default:          state_next = rcw_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_stall   = 1'b1;
    take_event = 1'b0;
    do_ack     = 1'b0;
    do_loss    = 1'b0;
    load_out   = 1'b0;
    case (state)
      rcw_pkg::ST_IDLE: begin
        // no transfer while reset is held
        in_stall   = rst;
        take_event = in_valid & !rst;
      end
      rcw_pkg::ST_ACK:  do_ack   = (ack_left != '0);
      rcw_pkg::ST_LOSS: do_loss  = 1'b1;
      rcw_pkg::ST_DONE: load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= rcw_pkg::ST_IDLE;
      window_limit      <= rcw_pkg::LIMIT_RESET;
      window_initial    <= rcw_pkg::WIN_INIT_RESET;
      threshold_initial <= rcw_pkg::THRESH_RESET;
      cwnd              <= WIN_INIT_X[WB-1:0];
      ssthresh          <= THRESH_X[WB-1:0];
      acc               <= '0;
      out_valid         <= 1'b0;
    end else begin
      state    <= state_next;
      cwnd     <= cwnd_next;
      ssthresh <= ssthresh_next;
      acc      <= acc_next;
      // the user must send config writes only while idle; the block does not enforce it
      if (cfg_write) begin
        case (reg_idx)
          rcw_pkg::REG_WINDOW_LIMIT: window_limit <= pwdata[15:0];
          rcw_pkg::REG_WINDOW_INITIAL: begin
            window_initial <= pwdata[15:0];
            cwnd           <= wdata_x[WB-1:0];
            acc            <= '0;
          end
          rcw_pkg::REG_THRESHOLD_INITIAL: begin
            threshold_initial <= pwdata[15:0];
            ssthresh          <= wdata_x[WB-1:0];
          end
          default: ;
        endcase
      end
      if (load_out)            out_valid <= 1'b1;
      else if (!out_stall)     out_valid <= 1'b0;
    end
  end

  // event and result payload
  logic [31:0] cwnd_x, ssthresh_x;
  assign cwnd_x     = 32'(cwnd);
  assign ssthresh_x = 32'(ssthresh);

  always_ff @(posedge clk) begin
    if (take_event) begin
      ack_left  <= (acked_count > ACK_CAP) ? ACK_CAP : acked_count;
      loss_mode <= rcw_pkg::loss_mode_t'(mode);
    end else if (do_ack) begin
      ack_left <= ack_left - ACK_ONE;
    end
    if (load_out) begin
      window    <= cwnd_x[15:0];
      threshold <= ssthresh_x[15:0];
    end
  end

endmodule
